[hw/rtl/rfc_pkg.sv]
package rfc_pkg;

   // Reply modes held in the mode register
   localparam logic [1:0] MODE_TEST   = 2'd0;
   localparam logic [1:0] MODE_SERIAL = 2'd1;
   localparam logic [1:0] MODE_RO     = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_SUCCESS  = 2'd0;
   localparam logic [1:0] ST_DATA_ERR = 2'd1;
   localparam logic [1:0] ST_MULTI    = 2'd2;
   localparam logic [1:0] ST_DEV_FAIL = 2'd3;

   // Frame layout
   localparam logic [8:0] POS_LEN      = 9'd2;
   localparam logic [8:0] POS_STATUS   = 9'd3;
   localparam logic [8:0] POS_INFO     = 9'd4;
   localparam logic [8:0] POS_ID_FIRST = 9'd5;
   localparam logic [8:0] POS_ID_LAST  = 9'd8;
   localparam logic [8:0] RO_LAST_POS  = 9'd13;
   localparam logic [9:0] FRAME_OVERHEAD = 10'd5;
   localparam logic [9:0] MIN_ID_TOTAL   = 10'd9;

   // Status and info byte codes
   localparam logic [7:0] STAT_OK    = 8'h00;
   localparam logic [7:0] STAT_FAIL  = 8'h01;
   localparam logic [7:0] INFO_OK    = 8'h00;
   localparam logic [7:0] INFO_MULTI = 8'h01;

   // Finished frame, as handed from the front to the back
   typedef struct packed {
      logic [1:0]  mode;
      logic        xor_ok;
      logic        long_ok;
      logic [7:0]  status_byte;
      logic [7:0]  info_byte;
      logic [31:0] id_bytes;
   } rfc_rec_type;

endpackage

[hw/rtl/rfid_reply_frame_checker.sv]
// Channel   Handshake              Payload
// request   push / full            req_rx_byte (8)
// response  pop / empty            rsp_status (2), rsp_card_id (32), rsp_fail_code (8)
// csr       csr_valid / csr_ready  csr_reply_mode (2)
//
// One byte is taken each cycle while the frame queue has room; the front updates the
// frame state in that cycle. The edge taking a frame's last byte writes the queue;
// the decoded result moves to the output register once it is free or being popped,
// and empty falls as it is loaded. The request side stalls only when the frame
// queue is full, which takes QUEUE_DEPTH + 1 unread results. Reset is synchronous
// and clears all frame state and sets the test reply mode; csr_ready is always high.
module rfid_reply_frame_checker #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        pop,
   output logic        empty,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_card_id,
   output logic [7:0]  rsp_fail_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_reply_mode
);

   rfc_pkg::rfc_rec_type front_rec;
   rfc_pkg::rfc_rec_type queue_rec;
   logic front_push;
   logic queue_full;
   logic queue_valid;
   logic back_take;
   logic take;

   // Accept a byte whenever the frame queue has room
   assign full      = queue_full;
   assign take      = push && !queue_full;
   assign csr_ready = 1'b1;

   rfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .cfg_write (csr_valid && csr_ready),
      .cfg_mode  (csr_reply_mode),
      .rec_push  (front_push),
      .rec       (front_rec)
   );

   rfc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_push),
      .wr_data  (front_rec),
      .full     (queue_full),
      .rd_en    (back_take),
      .rd_valid (queue_valid),
      .rd_data  (queue_rec)
   );

   rfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (queue_valid),
      .rec       (queue_rec),
      .rec_take  (back_take),
      .pop       (pop),
      .empty     (empty),
      .status    (rsp_status),
      .card_id   (rsp_card_id),
      .fail_code (rsp_fail_code)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !front_push)
      else $error("frame pushed into a full queue");

endmodule

[hw/rtl/rfc_front.sv]
module rfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         rx_byte,
   input  logic               cfg_write,
   input  logic [1:0]         cfg_mode,
   output logic               rec_push,
   output rfc_pkg::rfc_rec_type rec
);

   logic [1:0]  mode_ff, mode_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  stat_ff, stat_in;
   logic [7:0]  info_ff, info_in;
   logic [31:0] id_ff, id_in;

   logic [7:0]  xor_upd;
   logic [7:0]  stat_upd;
   logic [7:0]  info_upd;
   logic [31:0] id_upd;
   logic [9:0]  total;
   logic [9:0]  pos;
   logic        last;

   assign total = {2'b00, len_ff} + rfc_pkg::FRAME_OVERHEAD;
   assign pos   = {1'b0, count_ff};

   // Capture header fields and track the checksum for the byte on the input
   always_comb begin
      stat_upd = (count_ff == rfc_pkg::POS_STATUS) ? rx_byte : stat_ff;
      info_upd = (count_ff == rfc_pkg::POS_INFO) ? rx_byte : info_ff;
      id_upd   = id_ff;
      if (count_ff >= rfc_pkg::POS_ID_FIRST && count_ff <= rfc_pkg::POS_ID_LAST) begin
         id_upd = {id_ff[23:0], rx_byte};
      end
      xor_upd = xor_ff;
      if (count_ff < rfc_pkg::POS_STATUS) begin
         if (count_ff != 9'd0) begin
            xor_upd = xor_ff ^ rx_byte;
         end
      end else if (pos + 10'd2 <= total) begin
         xor_upd = xor_ff ^ rx_byte;
      end
      if (mode_ff == rfc_pkg::MODE_RO) begin
         last = (count_ff >= rfc_pkg::RO_LAST_POS);
      end else begin
         last = (count_ff >= rfc_pkg::POS_STATUS) && !(pos + 10'd1 < total);
      end
   end

   // Advance the frame state, and hand a finished frame to the queue
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      len_in   = len_ff;
      xor_in   = xor_ff;
      stat_in  = stat_ff;
      info_in  = info_ff;
      id_in    = id_ff;
      rec_push = 1'b0;
      if (cfg_write) begin
         mode_in  = cfg_mode;
         count_in = '0;
         len_in   = '0;
         xor_in   = '0;
         stat_in  = '0;
         info_in  = '0;
         id_in    = '0;
      end else if (take) begin
         if (last) begin
            rec_push = 1'b1;
            count_in = '0;
            len_in   = '0;
            xor_in   = '0;
            stat_in  = '0;
            info_in  = '0;
            id_in    = '0;
         end else begin
            count_in = count_ff + 9'd1;
            if (count_ff == rfc_pkg::POS_LEN && mode_ff != rfc_pkg::MODE_RO) begin
               len_in = rx_byte;
            end
            xor_in  = (mode_ff == rfc_pkg::MODE_RO) ? xor_ff : xor_upd;
            stat_in = stat_upd;
            info_in = info_upd;
            id_in   = id_upd;
         end
      end
   end

   assign rec.mode        = mode_ff;
   assign rec.xor_ok      = (xor_upd == 8'h00);
   assign rec.long_ok     = (total >= rfc_pkg::MIN_ID_TOTAL);
   assign rec.status_byte = stat_upd;
   assign rec.info_byte   = info_upd;
   assign rec.id_bytes    = id_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rfc_pkg::MODE_TEST;
         count_ff <= '0;
         len_ff   <= '0;
         xor_ff   <= '0;
         stat_ff  <= '0;
         info_ff  <= '0;
         id_ff    <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         xor_ff   <= xor_in;
         stat_ff  <= stat_in;
         info_ff  <= info_in;
         id_ff    <= id_in;
      end
   end

   // A read-only frame never runs past its fourteenth byte
   a_ro_count_bound: assert property (@(posedge clock) disable iff (reset)
      mode_ff == rfc_pkg::MODE_RO |-> count_ff <= rfc_pkg::RO_LAST_POS)
      else $error("read-only frame position out of range");

   // A finished frame leaves the position at the start
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      rec_push |=> count_ff == 9'd0)
      else $error("frame position not cleared after frame end");

endmodule

[hw/rtl/rfc_fifo.sv]
module rfc_fifo #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  rfc_pkg::rfc_rec_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output logic               rd_valid,
   output rfc_pkg::rfc_rec_type rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   rfc_pkg::rfc_rec_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_wr;
   logic          do_rd;

   assign full     = (cnt_ff == FULL_CNT);
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Advance the pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the written entry
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue fill count above depth");

   a_cnt_up: assert property (@(posedge clock) disable iff (reset)
      wr_en && !full && !(rd_en && rd_valid) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("queue fill count did not rise on write");

   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      rd_en && rd_valid && !wr_en |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("queue fill count did not fall on read");

endmodule

[hw/rtl/rfc_back.sv]
module rfc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_valid,
   input  rfc_pkg::rfc_rec_type rec,
   output logic               rec_take,
   input  logic               pop,
   output logic               empty,
   output logic [1:0]         status,
   output logic [31:0]        card_id,
   output logic [7:0]         fail_code
);

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  status_ff;
   logic [31:0] card_id_ff;
   logic [7:0]  fail_code_ff;
   logic [1:0]  dec_status;
   logic [31:0] dec_id;
   logic [7:0]  dec_fail;

   // Decode a finished frame into its result
   always_comb begin
      dec_status = rfc_pkg::ST_DATA_ERR;
      dec_id     = '0;
      dec_fail   = '0;
      priority if (rec.mode == rfc_pkg::MODE_RO) begin
         dec_status = rfc_pkg::ST_SUCCESS;
         dec_id     = rec.id_bytes;
      end else if (!rec.xor_ok) begin
         dec_status = rfc_pkg::ST_DATA_ERR;
      end else if (rec.mode == rfc_pkg::MODE_TEST) begin
         dec_status = rfc_pkg::ST_SUCCESS;
      end else if (rec.mode == rfc_pkg::MODE_SERIAL) begin
         if (rec.status_byte == rfc_pkg::STAT_OK) begin
            if (rec.info_byte == rfc_pkg::INFO_OK) begin
               if (rec.long_ok) begin
                  dec_status = rfc_pkg::ST_SUCCESS;
                  dec_id     = rec.id_bytes;
               end
            end else if (rec.info_byte == rfc_pkg::INFO_MULTI) begin
               dec_status = rfc_pkg::ST_MULTI;
            end
         end else if (rec.status_byte == rfc_pkg::STAT_FAIL) begin
            dec_status = rfc_pkg::ST_DEV_FAIL;
            dec_fail   = rec.info_byte;
         end
      end else begin
         dec_status = rfc_pkg::ST_DATA_ERR;
      end
   end

   // Load the output register when it is free or being drained
   assign rec_take = rec_valid && (!out_valid_ff || pop);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rec_take) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         status_ff    <= dec_status;
         card_id_ff   <= dec_id;
         fail_code_ff <= dec_fail;
      end
   end

   assign empty     = !out_valid_ff;
   assign status    = status_ff;
   assign card_id   = card_id_ff;
   assign fail_code = fail_code_ff;

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> out_valid_ff && $stable(status_ff) && $stable(card_id_ff))
      else $error("waiting result lost or changed");

   a_id_only_success: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff != rfc_pkg::ST_SUCCESS |-> card_id_ff == '0)
      else $error("card id set on a result that is not a success");

endmodule

[sim/rfid_reply_frame_checker_tb.sv]
`timescale 1ns / 1ps

module rfid_reply_frame_checker_tb;

   // The mode register is two bits wide; the top code has no reply format of its own
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_BYTES = 300;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] card_id;
      logic [7:0]  fail_code;
   } frame_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        pop = 1'b0;
   logic        empty;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_card_id;
   logic [7:0]  rsp_fail_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_reply_mode = rfc_pkg::MODE_TEST;

   // Frame tracking state, mirrored from the block
   logic [1:0]  cur_mode = rfc_pkg::MODE_TEST;
   logic [8:0]  fr_count = '0;
   logic [7:0]  fr_len = '0;
   logic [7:0]  fr_xor = '0;
   logic [7:0]  fr_status = '0;
   logic [7:0]  fr_info = '0;
   logic [31:0] fr_id = '0;

   frame_reply_type pending_replies[$];
   int mismatch_count = 0;
   int bytes_sent = 0;
   int burst_left = 0;
   int stall_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;

   rfid_reply_frame_checker dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_rx_byte    (req_rx_byte),
      .pop            (pop),
      .empty          (empty),
      .rsp_status     (rsp_status),
      .rsp_card_id    (rsp_card_id),
      .rsp_fail_code  (rsp_fail_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_reply_mode (csr_reply_mode)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
   endtask

   task automatic clear_frame();
      fr_count = '0;
      fr_len = '0;
      fr_xor = '0;
      fr_status = '0;
      fr_info = '0;
      fr_id = '0;
   endtask

   // Advance the frame state by one accepted byte; queue a reply at a frame end
   task automatic track_reply_byte(input logic [7:0] b);
      int idx;
      int total;
      bit done;
      frame_reply_type r;
      idx = fr_count;
      done = 1'b0;
      r.status = rfc_pkg::ST_DATA_ERR;
      r.card_id = '0;
      r.fail_code = '0;
      if (idx == rfc_pkg::POS_STATUS) fr_status = b;
      else if (idx == rfc_pkg::POS_INFO) fr_info = b;
      else if (idx >= rfc_pkg::POS_ID_FIRST && idx <= rfc_pkg::POS_ID_LAST)
         fr_id = {fr_id[23:0], b};

      if (cur_mode == rfc_pkg::MODE_RO) begin
         // fixed-size frame, no checksum
         if (idx >= rfc_pkg::RO_LAST_POS) begin
            r.status = rfc_pkg::ST_SUCCESS;
            r.card_id = fr_id;
            done = 1'b1;
         end else begin
            fr_count = 9'(idx + 1);
         end
      end else if (idx < rfc_pkg::POS_STATUS) begin
         if (idx == rfc_pkg::POS_LEN) fr_len = b;
         if (idx >= 1) fr_xor ^= b;
         fr_count = 9'(idx + 1);
      end else begin
         total = int'(fr_len) + int'(rfc_pkg::FRAME_OVERHEAD);
         if (idx + 2 <= total) fr_xor ^= b;
         if (idx + 1 < total) begin
            fr_count = 9'(idx + 1);
         end else begin
            done = 1'b1;
            if (fr_xor != 8'h00) begin
               r.status = rfc_pkg::ST_DATA_ERR;
            end else if (cur_mode == rfc_pkg::MODE_TEST) begin
               r.status = rfc_pkg::ST_SUCCESS;
            end else if (cur_mode == rfc_pkg::MODE_SERIAL) begin
               if (fr_status == rfc_pkg::STAT_OK) begin
                  if (fr_info == rfc_pkg::INFO_OK) begin
                     if (total >= rfc_pkg::MIN_ID_TOTAL) begin
                        r.status = rfc_pkg::ST_SUCCESS;
                        r.card_id = fr_id;
                     end
                  end else if (fr_info == rfc_pkg::INFO_MULTI) begin
                     r.status = rfc_pkg::ST_MULTI;
                  end
               end else if (fr_status == rfc_pkg::STAT_FAIL) begin
                  r.status = rfc_pkg::ST_DEV_FAIL;
                  r.fail_code = fr_info;
               end
            end
         end
      end

      if (done) begin
         pending_replies.push_back(r);
         clear_frame();
      end
   endtask

   // Send one byte; open a new burst with a random gap when the last one ran out
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
      track_reply_byte(b);
   endtask

   // Build a length-framed reply; status and info land at bytes 3 and 4 unless
   // the checksum or trailer falls there
   task automatic send_frame(input int len, input logic [7:0] stat, input logic [7:0] info,
                             input bit good_sum);
      logic [7:0] fb [0:259];
      logic [7:0] sum;
      int i;
      for (i = 0; i < len + 5; i++) fb[i] = 8'($urandom);
      fb[2] = 8'(len);
      fb[3] = stat;
      fb[4] = info;
      sum = 8'h00;
      for (i = 1; i <= len + 2; i++) sum ^= fb[i];
      fb[len + 3] = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
      for (i = 0; i < len + 5; i++) send_byte(fb[i]);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // Write the mode register once every expected reply has come back
   task automatic write_reply_mode(input logic [1:0] mode);
      @(negedge clock);
      push <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_reply_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cur_mode = mode;
      clear_frame();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_checksum_frames();
      // a hand-built shortest frame, then random shortest frames with good and bad sums
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
      send_frame(0, 8'h00, 8'h00, 1'b1);
      send_frame(0, 8'h00, 8'h00, 1'b0);
   endtask

   task automatic test_serial_decode();
      write_reply_mode(rfc_pkg::MODE_SERIAL);
      send_frame(4, rfc_pkg::STAT_OK, rfc_pkg::INFO_OK, 1'b1);
      send_frame(2, rfc_pkg::STAT_FAIL, 8'hFF, 1'b1);
   endtask

   task automatic test_read_only();
      write_reply_mode(rfc_pkg::MODE_RO);
      send_noise(14);
   endtask

   task automatic test_mode_write_abort();
      // drop a partial read-only frame, then a clean test-mode frame must pass
      send_noise(3);
      write_reply_mode(rfc_pkg::MODE_TEST);
      send_frame(0, 8'h00, 8'h00, 1'b1);
   endtask

   task automatic test_unused_mode();
      write_reply_mode(MODE_UNUSED);
      send_frame(1, rfc_pkg::STAT_OK, rfc_pkg::INFO_OK, 1'b1);
   endtask

   task automatic test_long_frame();
      // length byte with its top bit set, frame count past 255
      write_reply_mode(rfc_pkg::MODE_SERIAL);
      send_frame(255, rfc_pkg::STAT_OK, rfc_pkg::INFO_OK, 1'b1);
   endtask

   task automatic send_random_frame();
      int len;
      int pick;
      logic [7:0] stat;
      logic [7:0] info;
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(0, 8);
      else if (pick < 97) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 255);
      pick = $urandom_range(0, 99);
      if (pick < 50) stat = rfc_pkg::STAT_OK;
      else if (pick < 75) stat = rfc_pkg::STAT_FAIL;
      else stat = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) info = rfc_pkg::INFO_OK;
      else if (pick < 70) info = rfc_pkg::INFO_MULTI;
      else info = 8'($urandom);
      send_frame(len, stat, info, $urandom_range(0, 99) < 85);
   endtask

   // Phases of random mode, mostly well-formed frames with some noise between
   task automatic test_random_phases();
      int start;
      int frames;
      int pick;
      logic [1:0] mode;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) mode = rfc_pkg::MODE_TEST;
         else if (pick < 70) mode = rfc_pkg::MODE_SERIAL;
         else if (pick < 90) mode = rfc_pkg::MODE_RO;
         else mode = MODE_UNUSED;
         write_reply_mode(mode);
         frames = $urandom_range(2, 8);
         repeat (frames) begin
            if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4));
            if (mode == rfc_pkg::MODE_RO) send_noise(14);
            else send_random_frame();
         end
      end
   endtask

   // Receiver stalls on a rotating pattern, reloaded now and then
   always @(negedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               stall_pattern = 16'hFFFF;
            end
            1: begin
               stall_pattern = 16'h0001;
            end
            default: begin
               stall_pattern = 16'($urandom) | 16'h0001;
            end
         endcase
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      pop <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   // Compare each popped transaction with the oldest expected reply
   always @(posedge clock) begin : reply_check
      frame_reply_type want;
      if (!reset && pop && !empty) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply with none expected, status %0d", rsp_status));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_card_id !== want.card_id)
               report_mismatch($sformatf("card_id %h, expected %h", rsp_card_id, want.card_id));
            if (rsp_fail_code !== want.fail_code)
               report_mismatch($sformatf("fail_code %h, expected %h", rsp_fail_code,
                                         want.fail_code));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** rfid_reply_frame_checker: FAILED **");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_checksum_frames();
      test_serial_decode();
      test_read_only();
      test_mode_write_abort();
      test_unused_mode();
      test_long_frame();
      test_random_phases();

      // drain outstanding replies, then keep checking for stray replies
      @(negedge clock);
      push <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** rfid_reply_frame_checker: PASSED **");
      end else begin
         $display("** rfid_reply_frame_checker: FAILED **");
      end
      $finish;
   end

endmodule
